@@ hw/rtl/gqi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gqi_pkg
// Shared types and constants for the gyro quaternion integrator.
// ----------------------------------------------------------------------------
package gqi_pkg;

    localparam int VEC_W   = 32;
    localparam int DT_W    = 24;
    localparam int COEF_W  = 16;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROW2 = 2'd2;

    localparam logic [ROW_W-1:0] ROW0_RESET = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] ROW1_RESET = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 48'h4000_0000_0000;

    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    typedef enum logic [0:0] {
        UOP_SQRT = 1'b0,
        UOP_DIV  = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } unit_rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/gyro_quaternion_integrator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// From accept to result valid, an accelerometer request runs the rotation on the shared 33x33
// multiplier (its product is registered); a gyro request goes on to the quaternion update, the
// renormalization shifts and the bit-serial root and four divides.
// One request at a time; a new request is taken once the previous result is handed to the
// output register. An output stall holds the sequencer in its done state.
// Reset: identity rotation matrix, identity attitude quaternion, no result.
// ----------------------------------------------------------------------------
// gyro_quaternion_integrator
// Rotates sensor vectors to the board frame and integrates gyro rates into a
// unit attitude quaternion using one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
module gyro_quaternion_integrator
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire  [1:0]   cfg_index,
    input  wire  [47:0]  cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [119:0] s_axis_tdata,  // sensor_x, sensor_y, sensor_z, time_step
    input  wire          s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [223:0] m_axis_tdata,  // board_x/y/z, quat_w/x/y/z
    output logic         m_axis_tuser   // kind
);
    import gqi_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_ROT_MUL   = 13'b0000000000010,
        S_ROT_ACC   = 13'b0000000000100,
        S_INC_MUL   = 13'b0000000001000,
        S_INC_ACC   = 13'b0000000010000,
        S_QP_MUL    = 13'b0000000100000,
        S_QP_ACC    = 13'b0000001000000,
        S_NORM      = 13'b0000010000000,
        S_SQ_MUL    = 13'b0000100000000,
        S_SQ_ACC    = 13'b0001000000000,
        S_SQRT      = 13'b0010000000000,
        S_DIV       = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic        go_reg, go_next;
    logic [3:0]  idx_reg, idx_next;
    logic [1:0]  col_reg, col_next;
    logic        mode_reg, mode_next;
    logic [ROW_W-1:0] row_reg [3];
    logic signed [31:0] vin_reg [3];
    logic signed [31:0] vin_next [3];
    logic [DT_W-1:0] dt_reg, dt_next;
    logic signed [31:0] b_reg [3];
    logic signed [31:0] b_next [3];
    logic signed [31:0] p_reg [3];
    logic signed [31:0] p_next [3];
    logic signed [31:0] q_reg [4];
    logic signed [31:0] q_next [4];
    logic [62:0] mag_reg [4];
    logic [62:0] mag_next [4];
    logic [3:0]  neg_reg, neg_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [31:0] s_reg, s_next;
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg;
    logic [31:0] out_b_reg [3];
    logic [31:0] out_q_reg [4];
    logic        out_load;

    unit_req_t   ureq;
    unit_rsp_t   ursp;
    logic [63:0] u_operand;

    logic [47:0] row_sel;
    logic signed [15:0] coef;
    logic signed [31:0] vin_sel;
    logic signed [31:0] b_sel;
    logic [1:0]  p_idx;
    logic signed [32:0] p_val;
    logic signed [63:0] prod64;
    logic signed [63:0] sum;
    logic signed [63:0] rnd;
    logic signed [63:0] term;
    logic [63:0] abs_m;
    logic        minus;
    logic        big;
    logic        small_all;
    logic        zero_all;
    logic [31:0] qdiv;

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF)
            return 32'h7FFF_FFFF;
        else if (x < -64'sh0000_0000_8000_0000)
            return 32'h8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic qp_minus(input logic [1:0] k, input logic [1:0] t);
        case (k)
            2'd0:    return t != 2'd0;
            2'd1:    return t == 2'd3;
            2'd2:    return t == 2'd1;
            2'd3:    return t == 2'd2;
            default: return 1'b0;
        endcase
    endfunction

    gqi_iter_unit u_iter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ureq),
        .operand (u_operand),
        .divisor (s_reg),
        .rsp     (ursp)
    );

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    row_sel = row_reg[0];
            2'd1:    row_sel = row_reg[1];
            default: row_sel = row_reg[2];
        endcase
        case (col_reg)
            2'd0:
            begin
                coef    = row_sel[15:0];
                vin_sel = vin_reg[0];
            end
            2'd1:
            begin
                coef    = row_sel[31:16];
                vin_sel = vin_reg[1];
            end
            default:
            begin
                coef    = row_sel[47:32];
                vin_sel = vin_reg[2];
            end
        endcase
        case (idx_reg[1:0])
            2'd0:    b_sel = b_reg[0];
            2'd1:    b_sel = b_reg[1];
            default: b_sel = b_reg[2];
        endcase
        p_idx = idx_reg[3:2] ^ idx_reg[1:0];
        case (p_idx)
            2'd0:    p_val = {Q30_ONE[31], Q30_ONE};
            2'd1:    p_val = {p_reg[0][31], p_reg[0]};
            2'd2:    p_val = {p_reg[1][31], p_reg[1]};
            default: p_val = {p_reg[2][31], p_reg[2]};
        endcase
        case (state_reg)
            S_ROT_MUL:
            begin
                mul_a = {{17{coef[15]}}, coef};
                mul_b = {vin_sel[31], vin_sel};
            end
            S_INC_MUL:
            begin
                mul_a = {9'd0, dt_reg};
                mul_b = {b_sel[31], b_sel};
            end
            S_QP_MUL:
            begin
                mul_a = {q_reg[idx_reg[1:0]][31], q_reg[idx_reg[1:0]]};
                mul_b = p_val;
            end
            S_SQ_MUL:
            begin
                mul_a = {3'd0, mag_reg[idx_reg[1:0]][29:0]};
                mul_b = {3'd0, mag_reg[idx_reg[1:0]][29:0]};
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod64 = prod_reg[63:0];

    always_comb
    begin
        state_next     = state_reg;
        go_next        = 1'b0;
        idx_next       = idx_reg;
        col_next       = col_reg;
        mode_next      = mode_reg;
        vin_next       = vin_reg;
        dt_next        = dt_reg;
        b_next         = b_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        s_next         = s_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        ureq.start     = 1'b0;
        ureq.op        = UOP_SQRT;
        u_operand      = acc_reg;
        sum            = 64'sd0;
        rnd            = 64'sd0;
        term           = 64'sd0;
        abs_m          = 64'd0;
        minus          = 1'b0;
        qdiv           = 32'd0;
        big            = 1'b0;
        small_all      = 1'b1;
        zero_all       = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            big       = big | (mag_reg[i][62:30] != 33'd0);
            small_all = small_all & ~mag_reg[i][29];
            zero_all  = zero_all & (mag_reg[i] == 63'd0);
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next   = s_axis_tuser;
                    vin_next[0] = s_axis_tdata[31:0];
                    vin_next[1] = s_axis_tdata[63:32];
                    vin_next[2] = s_axis_tdata[95:64];
                    dt_next     = s_axis_tdata[119:96];
                    idx_next    = 4'd0;
                    col_next    = 2'd0;
                    acc_next    = 64'sd0;
                    state_next  = S_ROT_MUL;
                end
            end
            S_ROT_MUL:
            begin
                state_next = S_ROT_ACC;
            end
            S_ROT_ACC:
            begin
                sum = acc_reg + prod64;
                if (col_reg == 2'd2)
                begin
                    rnd = (sum + 64'sd8192) >>> 14;
                    b_next[idx_reg[1:0]] = sat32(rnd);
                    acc_next = 64'sd0;
                    col_next = 2'd0;
                    if (idx_reg[1:0] == 2'd2)
                    begin
                        idx_next   = 4'd0;
                        state_next = mode_reg ? S_DONE : S_INC_MUL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = S_ROT_MUL;
                    end
                end
                else
                begin
                    acc_next   = sum;
                    col_next   = col_reg + 2'd1;
                    state_next = S_ROT_MUL;
                end
            end
            S_INC_MUL:
            begin
                state_next = S_INC_ACC;
            end
            S_INC_ACC:
            begin
                rnd = (prod64 + 64'sd1024) >>> 11;
                p_next[idx_reg[1:0]] = sat32(rnd);
                if (idx_reg[1:0] == 2'd2)
                begin
                    idx_next   = 4'd0;
                    acc_next   = 64'sd0;
                    state_next = S_QP_MUL;
                end
                else
                begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = S_INC_MUL;
                end
            end
            S_QP_MUL:
            begin
                state_next = S_QP_ACC;
            end
            S_QP_ACC:
            begin
                term  = prod64 >>> 2;
                minus = qp_minus(idx_reg[3:2], idx_reg[1:0]);
                sum   = minus ? acc_reg - term : acc_reg + term;
                idx_next   = idx_reg + 4'd1;
                state_next = S_QP_MUL;
                if (idx_reg[1:0] == 2'd3)
                begin
                    abs_m = sum[63] ? 64'd0 - sum : sum;
                    mag_next[idx_reg[3:2]] = abs_m[62:0];
                    neg_next[idx_reg[3:2]] = sum[63];
                    acc_next = 64'sd0;
                    if (idx_reg == 4'd15)
                    begin
                        state_next = S_NORM;
                    end
                end
                else
                begin
                    acc_next = sum;
                end
            end
            S_NORM:
            begin
                idx_next = 4'd0;
                if (zero_all)
                begin
                    state_next = S_DONE;
                end
                else if (big)
                begin
                    for (int i = 0; i < 4; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else if (small_all)
                begin
                    for (int i = 0; i < 4; i++)
                        mag_next[i] = mag_reg[i] << 1;
                end
                else
                begin
                    acc_next   = 64'sd0;
                    state_next = S_SQ_MUL;
                end
            end
            S_SQ_MUL:
            begin
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                acc_next = acc_reg + prod64;
                idx_next = idx_reg + 4'd1;
                if (idx_reg[1:0] == 2'd3)
                begin
                    go_next    = 1'b1;
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_SQ_MUL;
                end
            end
            S_SQRT:
            begin
                ureq.start = go_reg;
                ureq.op    = UOP_SQRT;
                u_operand  = acc_reg;
                if (ursp.done)
                begin
                    s_next   = ursp.result;
                    idx_next = 4'd0;
                    if (ursp.result == 32'd0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        go_next    = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                ureq.start = go_reg;
                ureq.op    = UOP_DIV;
                u_operand  = {4'd0, mag_reg[idx_reg[1:0]][29:0], 30'd0}
                           + {33'd0, s_reg[31:1]};
                if (ursp.done)
                begin
                    qdiv = (ursp.result > 32'h4000_0000) ? 32'h4000_0000 : ursp.result;
                    q_next[idx_reg[1:0]] = neg_reg[idx_reg[1:0]] ? 32'd0 - qdiv : qdiv;
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        go_next = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg[0]    <= ROW0_RESET;
            row_reg[1]    <= ROW1_RESET;
            row_reg[2]    <= ROW2_RESET;
            q_reg[0]      <= Q30_ONE;
            q_reg[1]      <= 32'sd0;
            q_reg[2]      <= 32'sd0;
            q_reg[3]      <= 32'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            q_reg         <= q_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW0: row_reg[0] <= cfg_data;
                    REG_ROW1: row_reg[1] <= cfg_data;
                    REG_ROW2: row_reg[2] <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        col_reg  <= col_next;
        mode_reg <= mode_next;
        vin_reg  <= vin_next;
        dt_reg   <= dt_next;
        b_reg    <= b_next;
        p_reg    <= p_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        s_reg    <= s_next;
        if (out_load)
        begin
            out_kind_reg <= mode_reg;
            for (int i = 0; i < 3; i++)
                out_b_reg[i] <= b_reg[i];
            for (int i = 0; i < 4; i++)
                out_q_reg[i] <= q_reg[i];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {out_q_reg[3], out_q_reg[2], out_q_reg[1], out_q_reg[0],
                            out_b_reg[2], out_b_reg[1], out_b_reg[0]};

endmodule
`default_nettype wire

@@ hw/rtl/gqi_iter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gqi_iter_unit
// Bit-serial square root and divide unit, 32 steps per operation.
// Square root: floor root of a 64-bit operand.
// Divide: 32-bit quotient of operand by divisor; operand[63:32] must be
// below the divisor.
// ----------------------------------------------------------------------------
module gqi_iter_unit
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  gqi_pkg::unit_req_t   req,
    input  wire  [63:0]          operand,
    input  wire  [31:0]          divisor,
    output gqi_pkg::unit_rsp_t   rsp
);
    import gqi_pkg::*;

    logic [63:0] r_reg, r_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] bit_reg, bit_next;
    logic [31:0] d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    unit_op_t    op_reg, op_next;

    logic [63:0] trial_sum;
    logic [33:0] trial_div;

    always_comb
    begin
        r_next    = r_reg;
        v_next    = v_reg;
        bit_next  = bit_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        trial_sum = r_reg + bit_reg;
        trial_div = {1'b0, r_reg[31:0], v_reg[31]} - {2'b00, d_reg};
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            d_next    = divisor;
            bit_next  = 64'd1 << 62;
            if (req.op == UOP_SQRT)
            begin
                r_next = 64'd0;
                v_next = operand;
            end
            else
            begin
                r_next = {32'd0, operand[63:32]};
                v_next = {32'd0, operand[31:0]};
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == UOP_SQRT)
            begin
                if (v_reg >= trial_sum)
                begin
                    v_next = v_reg - trial_sum;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            else
            begin
                if (!trial_div[33])
                begin
                    r_next = {31'd0, trial_div[32:0]};
                    v_next = {32'd0, v_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = {31'd0, r_reg[31:0], v_reg[31]};
                    v_next = {32'd0, v_reg[30:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            op_reg   <= UOP_SQRT;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        v_reg   <= v_next;
        bit_reg <= bit_next;
        d_reg   <= d_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == UOP_SQRT) ? r_reg[31:0] : v_reg[31:0];

endmodule
`default_nettype wire
